### design/cordic_sine_cosine_turns_unit_assert.svh
// Assertion macros for the CORDIC sine/cosine unit checker.
`ifndef CORDIC_SINE_COSINE_TURNS_UNIT_ASSERT_SVH
`define CORDIC_SINE_COSINE_TURNS_UNIT_ASSERT_SVH

// Clocked assertion, disabled while reset is asserted.
`define CSC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define CSC_NEVER(lbl, cond, msg) `CSC_ASSERT(lbl, !(cond), msg)

`endif

### design/csc_pkg.sv
// Shared types, constants and the arctangent table of the CORDIC sine/cosine unit.
`timescale 1ns / 1ps

package csc_pkg;

    localparam int STEPS   = 16;
    localparam int STEP_W  = $clog2(STEPS);
    localparam int IN_W    = 16;
    localparam int ANG_W   = IN_W + 2;
    localparam int DATA_W  = 34;
    localparam int OUT_W   = 32;
    localparam int ADDR_W  = 3;
    localparam int LATENCY = STEPS + 2;

    localparam logic signed [DATA_W-1:0] GAIN         = 34'sd652032874;
    localparam logic signed [ANG_W-1:0]  ANG_HALF     = 18'sd32768;
    localparam logic signed [ANG_W-1:0]  ANG_QUARTER  = 18'sd16384;
    localparam logic [IN_W-1:0]          QUARTER_STEP = 16'd16384;

    localparam logic REG_TRIG_MODE = 1'b0;

    typedef enum logic
    {
        MODE_CORDIC = 1'b0,
        MODE_FAST   = 1'b1
    } trig_mode_t;

    typedef struct packed
    {
        logic                      fast;
        logic                      neg;
        logic signed [ANG_W-1:0]   ang;
        logic signed [DATA_W-1:0]  x;
        logic signed [DATA_W-1:0]  y;
    } stage_t;

    function automatic logic signed [ANG_W-1:0] atan_turns(input logic [STEP_W-1:0] i);
        logic signed [ANG_W-1:0] r;
        case (i)
            4'd0:    r = 18'sd8192;
            4'd1:    r = 18'sd4836;
            4'd2:    r = 18'sd2555;
            4'd3:    r = 18'sd1297;
            4'd4:    r = 18'sd651;
            4'd5:    r = 18'sd326;
            4'd6:    r = 18'sd163;
            4'd7:    r = 18'sd82;
            4'd8:    r = 18'sd41;
            4'd9:    r = 18'sd20;
            4'd10:   r = 18'sd10;
            4'd11:   r = 18'sd5;
            4'd12:   r = 18'sd3;
            4'd13:   r = 18'sd1;
            4'd14:   r = 18'sd1;
            default: r = 18'sd0;
        endcase
        return r;
    endfunction

endpackage

### design/csc_prep.sv
// Entry cell: quadrant fold for CORDIC and parabola sine/cosine for the fast mode.
`timescale 1ns / 1ps

module csc_prep
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [csc_pkg::IN_W-1:0]   angle_turns,
    input  csc_pkg::trig_mode_t        mode,
    output logic                       out_valid,
    output csc_pkg::stage_t            out_stage
);

    logic                                 valid_reg;
    csc_pkg::stage_t                      stage_reg;
    csc_pkg::stage_t                      stage_next;
    logic signed [csc_pkg::ANG_W-1:0]     ang0;
    logic [csc_pkg::IN_W-1:0]             cos_angle;
    logic signed [csc_pkg::DATA_W-1:0]    par_sin;
    logic signed [csc_pkg::DATA_W-1:0]    par_cos;

    // 4*p*(1-|p|) in Q30 reduces exactly to 4*phase*(32768-|phase|)
    function automatic logic signed [csc_pkg::DATA_W-1:0] parabola(
        input logic [csc_pkg::IN_W-1:0] a);
        logic signed [csc_pkg::IN_W:0]     ph;
        logic signed [csc_pkg::IN_W:0]     mag;
        logic signed [csc_pkg::IN_W:0]     rem;
        logic signed [csc_pkg::DATA_W-1:0] prod;
        ph   = (csc_pkg::IN_W + 1)'($signed(a));
        mag  = (ph < 0) ? -ph : ph;
        rem  = 17'sd32768 - mag;
        prod = csc_pkg::DATA_W'(ph) * csc_pkg::DATA_W'(rem);
        return prod <<< 2;
    endfunction

    always_comb
    begin
        ang0      = csc_pkg::ANG_W'($signed(angle_turns));
        cos_angle = angle_turns + csc_pkg::QUARTER_STEP;
        par_sin   = parabola(angle_turns);
        par_cos   = parabola(cos_angle);

        stage_next.fast = (mode == csc_pkg::MODE_FAST);
        stage_next.neg  = 1'b0;
        stage_next.ang  = ang0;
        stage_next.x    = csc_pkg::GAIN;
        stage_next.y    = '0;
        if (mode == csc_pkg::MODE_FAST)
        begin
            stage_next.x = par_cos;
            stage_next.y = par_sin;
        end
        else if (ang0 > csc_pkg::ANG_QUARTER)
        begin
            stage_next.ang = ang0 - csc_pkg::ANG_HALF;
            stage_next.neg = 1'b1;
        end
        else if (ang0 < -csc_pkg::ANG_QUARTER)
        begin
            stage_next.ang = ang0 + csc_pkg::ANG_HALF;
            stage_next.neg = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

### design/csc_cell.sv
// One CORDIC rotation cell of the chain; fast-mode items pass through unchanged.
`timescale 1ns / 1ps

module csc_cell
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [csc_pkg::STEP_W-1:0]  step,
    input  logic                        in_valid,
    input  csc_pkg::stage_t             in_stage,
    output logic                        out_valid,
    output csc_pkg::stage_t             out_stage
);

    logic                               valid_reg;
    csc_pkg::stage_t                    stage_reg;
    csc_pkg::stage_t                    stage_next;
    logic signed [csc_pkg::DATA_W-1:0]  xs;
    logic signed [csc_pkg::DATA_W-1:0]  ys;
    logic signed [csc_pkg::ANG_W-1:0]   atan;

    always_comb
    begin
        xs         = in_stage.x >>> step;
        ys         = in_stage.y >>> step;
        atan       = csc_pkg::atan_turns(step);
        stage_next = in_stage;
        if (!in_stage.fast)
        begin
            if (in_stage.ang >= 0)
            begin
                stage_next.x   = in_stage.x - ys;
                stage_next.y   = in_stage.y + xs;
                stage_next.ang = in_stage.ang - atan;
            end
            else
            begin
                stage_next.x   = in_stage.x + ys;
                stage_next.y   = in_stage.y - xs;
                stage_next.ang = in_stage.ang + atan;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

### design/cordic_sine_cosine_turns_unit.sv
// Top level of the CORDIC sine/cosine unit: register port, cell chain and result register.
`timescale 1ns / 1ps
//
// Usage:
//   Angle in: pulse start with angle_turns (65536 per turn). busy is always low,
//   so a transfer is accepted every cycle start is high.
//   Result out: done is high for one cycle with sine_q30 and cosine_q30 (Q30).
//   From the accepting edge an angle passes one entry cell (fold or parabola
//   multiply), sixteen rotation cells and one result register.
//   Throughput is one angle per cycle; every cell works on a different angle.
//   Register port: trig_mode at address 0 (0 = CORDIC, 1 = parabola). The mode
//   travels with each angle, so results in flight keep the mode they entered with.
//   Reset clears trig_mode to CORDIC and empties the chain; angles in flight at
//   reset are dropped and no done follows until a new angle is accepted.
//   The receiver has no backpressure: results must be taken when done is high.
//
module cordic_sine_cosine_turns_unit
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [csc_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           start,
    output logic                           busy,
    input  logic [csc_pkg::IN_W-1:0]       angle_turns,
    output logic                           done,
    output logic signed [csc_pkg::OUT_W-1:0] sine_q30,
    output logic signed [csc_pkg::OUT_W-1:0] cosine_q30
);

    csc_pkg::trig_mode_t                  mode_reg;
    logic                                 cfg_write;
    logic                                 chain_valid [0:csc_pkg::STEPS];
    csc_pkg::stage_t                      chain_stage [0:csc_pkg::STEPS];
    csc_pkg::stage_t                      last;
    logic                                 done_reg;
    logic signed [csc_pkg::OUT_W-1:0]     sine_reg;
    logic signed [csc_pkg::OUT_W-1:0]     cosine_reg;
    logic signed [csc_pkg::OUT_W-1:0]     sine_next;
    logic signed [csc_pkg::OUT_W-1:0]     cosine_next;

    assign pready    = 1'b1;
    assign busy      = 1'b0;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == csc_pkg::REG_TRIG_MODE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= csc_pkg::MODE_CORDIC;
        end
        else if (cfg_write)
        begin
            mode_reg <= csc_pkg::trig_mode_t'(pwdata[0]);
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == csc_pkg::REG_TRIG_MODE)
        begin
            prdata[0] = mode_reg;
        end
    end

    csc_prep u_prep
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (start && !busy),
        .angle_turns (angle_turns),
        .mode        (mode_reg),
        .out_valid   (chain_valid[0]),
        .out_stage   (chain_stage[0])
    );

    for (genvar g = 0; g < csc_pkg::STEPS; g++)
    begin : g_cell
        csc_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .step      (csc_pkg::STEP_W'(g)),
            .in_valid  (chain_valid[g]),
            .in_stage  (chain_stage[g]),
            .out_valid (chain_valid[g+1]),
            .out_stage (chain_stage[g+1])
        );
    end

    always_comb
    begin
        last        = chain_stage[csc_pkg::STEPS];
        sine_next   = last.neg ? csc_pkg::OUT_W'(-last.y) : csc_pkg::OUT_W'(last.y);
        cosine_next = last.neg ? csc_pkg::OUT_W'(-last.x) : csc_pkg::OUT_W'(last.x);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= chain_valid[csc_pkg::STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        sine_reg   <= sine_next;
        cosine_reg <= cosine_next;
    end

    assign done       = done_reg;
    assign sine_q30   = sine_reg;
    assign cosine_q30 = cosine_reg;

endmodule

### design/csc_check.sv
// Port-level checker for the CORDIC sine/cosine unit and its bind.
`timescale 1ns / 1ps
`include "cordic_sine_cosine_turns_unit_assert.svh"

module csc_check
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic pready
);

    localparam int LAT = csc_pkg::LATENCY;

    `CSC_NEVER(a_never_busy, busy, "busy raised")
    `CSC_NEVER(a_pready_low, !pready, "pready dropped")
    `CSC_ASSERT(a_result_follows, start && !busy |-> ##LAT done, "result missing")
    `CSC_ASSERT(a_no_spurious, done |-> $past(start && !busy, LAT), "result without transfer")

endmodule

bind cordic_sine_cosine_turns_unit csc_check u_check (.*);
